// ----- design/aled_ser_pkg.sv -----
// shared types, constants and reset values for the addressable led serializer
// no dependencies; imported by every module of the block

package aled_ser_pkg;

    // field widths
    localparam int unsigned CHAN_W         = 8;
    localparam int unsigned TICK_W         = 15;
    localparam int unsigned BITS_PER_PIXEL = 24;
    localparam int unsigned SYM_CNT_W      = $clog2(BITS_PER_PIXEL + 1);
    localparam int unsigned PROD_W         = 2 * CHAN_W;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration port
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned REG_IDX_W = 3;

    // timing defaults, derived from line times at the tick rate
    localparam longint unsigned TICK_HZ      = 64'd10000000;
    localparam longint unsigned ZERO_HIGH_NS = 64'd350;
    localparam longint unsigned ZERO_LOW_NS  = 64'd900;
    localparam longint unsigned ONE_HIGH_NS  = 64'd900;
    localparam longint unsigned ONE_LOW_NS   = 64'd350;
    localparam longint unsigned LATCH_US     = 64'd280;

    localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  =
        TICK_W'(ZERO_HIGH_NS * TICK_HZ / 64'd1000000000);
    localparam logic [TICK_W-1:0] ZERO_LOW_RST   =
        TICK_W'(ZERO_LOW_NS * TICK_HZ / 64'd1000000000);
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   =
        TICK_W'(ONE_HIGH_NS * TICK_HZ / 64'd1000000000);
    localparam logic [TICK_W-1:0] ONE_LOW_RST    =
        TICK_W'(ONE_LOW_NS * TICK_HZ / 64'd1000000000);
    localparam logic [TICK_W-1:0] LATCH_RST      =
        TICK_W'(LATCH_US * TICK_HZ / 64'd1000000);

    // register indexes on the configuration port
    typedef enum logic [REG_IDX_W-1:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_ZERO_HIGH  = 3'd1,
        REG_ZERO_LOW   = 3'd2,
        REG_ONE_HIGH   = 3'd3,
        REG_ONE_LOW    = 3'd4,
        REG_LATCH      = 3'd5
    } t_reg_idx;

    // one scaled pixel, green/red/blue msb first, plus frame flag
    typedef struct packed {
        logic [BITS_PER_PIXEL-1:0] word;
        logic                      last;
    } t_pix;

    // symbol timing handed to the back end
    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] latch;
    } t_sym_cfg;

endpackage

// ----- design/aled_ser_fifo.sv -----
// short register queue carrying scaled pixels from front to back
// depends on aled_ser_pkg for the item type

module aled_ser_fifo import aled_ser_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_pix i_wr_data,
    output logic o_full,
    input  logic i_rd,
    output t_pix o_rd_data,
    output logic o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_pix          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ----- design/aled_ser_front.sv -----
// front end: takes pixels, scales each channel by brightness/255 and queues them
// depends on aled_ser_pkg

module aled_ser_front import aled_ser_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    input  logic              i_last_pixel,
    input  logic [CHAN_W-1:0] i_brightness,
    output logic              o_q_wr,
    output t_pix              o_q_data,
    input  logic              i_q_full
);

    logic              r_valid;
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic              r_last;
    logic [CHAN_W-1:0] scaled_r, scaled_g, scaled_b;

    // exact divide by 255 for 16-bit products: (p + p/256 + 1) / 256
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] sum;
        sum = p + {{CHAN_W{1'b0}}, p[PROD_W-1:CHAN_W]} + PROD_W'(1);
        return sum[PROD_W-1:CHAN_W];
    endfunction

    // product stage holds while the queue is full
    assign o_full = r_valid && i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_full) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_prod_r <= i_red * i_brightness;
            r_prod_g <= i_green * i_brightness;
            r_prod_b <= i_blue * i_brightness;
            r_last   <= i_last_pixel;
        end
    end

    // reciprocal correction and packing into the queue
    assign scaled_r = div255(r_prod_r);
    assign scaled_g = div255(r_prod_g);
    assign scaled_b = div255(r_prod_b);

    assign o_q_wr        = r_valid;
    assign o_q_data.word = {scaled_g, scaled_r, scaled_b};
    assign o_q_data.last = r_last;

endmodule

// ----- design/aled_ser_back.sv -----
// back end: turns each queued pixel into bit symbols and an optional latch symbol
// depends on aled_ser_pkg

module aled_ser_back import aled_ser_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_pix              i_q_data,
    output logic              o_q_rd,
    input  t_sym_cfg          i_cfg,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_first_level,
    output logic [TICK_W-1:0] o_first_ticks,
    output logic              o_second_level,
    output logic [TICK_W-1:0] o_second_ticks,
    output logic              o_frame_end
);

    localparam logic [SYM_CNT_W-1:0] LAST_BIT  = SYM_CNT_W'(BITS_PER_PIXEL - 1);
    localparam logic [SYM_CNT_W-1:0] LATCH_SYM = SYM_CNT_W'(BITS_PER_PIXEL);

    logic                      r_busy;
    logic [SYM_CNT_W-1:0]      r_cnt;
    logic [BITS_PER_PIXEL-1:0] r_word;
    logic                      r_last;
    logic                      r_out_valid;
    logic                      r_first_level, r_second_level, r_frame_end;
    logic [TICK_W-1:0]         r_first_ticks, r_second_ticks;

    logic              out_free, emit, done, load, is_latch, bit_one;
    logic [TICK_W-1:0] sym_first, sym_second;

    // slot handshake
    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_busy && out_free;
    assign done     = emit && ((r_cnt == LAST_BIT && !r_last) || r_cnt == LATCH_SYM);
    assign load     = !i_q_empty && (!r_busy || done);
    assign o_q_rd   = load;

    // symbol selection
    assign is_latch   = (r_cnt == LATCH_SYM);
    assign bit_one    = r_word[BITS_PER_PIXEL-1];
    assign sym_first  = is_latch ? i_cfg.latch : (bit_one ? i_cfg.one_high : i_cfg.zero_high);
    assign sym_second = is_latch ? i_cfg.latch : (bit_one ? i_cfg.one_low : i_cfg.zero_low);

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // pixel word, shifted one bit per symbol
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_q_data.word;
            r_last <= i_q_data.last;
        end else if (emit) begin
            r_word <= {r_word[BITS_PER_PIXEL-2:0], 1'b0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_first_level  <= !is_latch;
            r_first_ticks  <= sym_first;
            r_second_level <= 1'b0;
            r_second_ticks <= sym_second;
            r_frame_end    <= is_latch;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_first_level  = r_first_level;
    assign o_first_ticks  = r_first_ticks;
    assign o_second_level = r_second_level;
    assign o_second_ticks = r_second_ticks;
    assign o_frame_end    = r_frame_end;

endmodule

// ----- design/addressable_led_serializer_unit.sv -----
// top level of the addressable led serializer: config registers, front, queue, back
// depends on aled_ser_pkg, aled_ser_front, aled_ser_fifo and aled_ser_back
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------------------------
//  pixel     | in        | push / full                | i_red i_green i_blue i_last_pixel
//  symbol    | out       | empty / pop                | o_first_level o_first_ticks
//            |           |                            | o_second_level o_second_ticks o_frame_end
//  config    | in        | apb psel penable pwrite    | paddr pwdata prdata (pready tied high)
//
// each pixel gives 24 symbols, 25 when it closes a frame, one symbol per cycle from the
// back end's output register unless pop stalls; the sequencer loads the next pixel as it
// emits the last symbol of the current one. a pixel reaches the result ports through the
// product register, queue, sequencer word register and output register. reset is synchronous
// and clears control state and the config registers to their defaults. a stall on pop holds
// the output register; the queue then fills and full rises, while either side may stall alone.

module addressable_led_serializer_unit import aled_ser_pkg::*; #(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel items
    input  logic               push,
    output logic               full,
    input  logic [CHAN_W-1:0]  i_red,
    input  logic [CHAN_W-1:0]  i_green,
    input  logic [CHAN_W-1:0]  i_blue,
    input  logic               i_last_pixel,
    // symbol items
    output logic               empty,
    input  logic               pop,
    output logic               o_first_level,
    output logic [TICK_W-1:0]  o_first_ticks,
    output logic               o_second_level,
    output logic [TICK_W-1:0]  o_second_ticks,
    output logic               o_frame_end,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CHAN_W-1:0] r_brightness;
    t_sym_cfg          r_cfg;
    logic              cfg_wr;
    t_reg_idx          reg_idx;

    logic q_wr, q_full, q_rd, q_empty;
    t_pix q_wr_data, q_rd_data;

    // register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness    <= BRIGHTNESS_RST;
            r_cfg.zero_high <= ZERO_HIGH_RST;
            r_cfg.zero_low  <= ZERO_LOW_RST;
            r_cfg.one_high  <= ONE_HIGH_RST;
            r_cfg.one_low   <= ONE_LOW_RST;
            r_cfg.latch     <= LATCH_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_BRIGHTNESS: r_brightness    <= pwdata[CHAN_W-1:0];
                REG_ZERO_HIGH:  r_cfg.zero_high <= pwdata[TICK_W-1:0];
                REG_ZERO_LOW:   r_cfg.zero_low  <= pwdata[TICK_W-1:0];
                REG_ONE_HIGH:   r_cfg.one_high  <= pwdata[TICK_W-1:0];
                REG_ONE_LOW:    r_cfg.one_low   <= pwdata[TICK_W-1:0];
                REG_LATCH:      r_cfg.latch     <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_BRIGHTNESS: prdata = PDATA_W'(r_brightness);
            REG_ZERO_HIGH:  prdata = PDATA_W'(r_cfg.zero_high);
            REG_ZERO_LOW:   prdata = PDATA_W'(r_cfg.zero_low);
            REG_ONE_HIGH:   prdata = PDATA_W'(r_cfg.one_high);
            REG_ONE_LOW:    prdata = PDATA_W'(r_cfg.one_low);
            REG_LATCH:      prdata = PDATA_W'(r_cfg.latch);
            default:        prdata = '0;
        endcase
    end

    // scaling front end
    aled_ser_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .i_brightness (r_brightness),
        .o_q_wr       (q_wr),
        .o_q_data     (q_wr_data),
        .i_q_full     (q_full)
    );

    // pixel queue
    aled_ser_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // symbol back end
    aled_ser_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_rd_data),
        .o_q_rd         (q_rd),
        .i_cfg          (r_cfg),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_frame_end    (o_frame_end)
    );

endmodule
